>>> design/assert_macros.svh
// Assertion macros shared by the point gate filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define PROP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define PROP_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");

`else

`define PROP_ASSERT(lbl, clk, rst_n, prop)

`define PROP_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

>>> design/lpgf_pkg.sv
// Shared types and constants of the lidar point gate filter.
package lpgf_pkg;

    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int MODE_W      = 2;
    localparam int KEEP_W      = 16;
    localparam int RANGE_W     = 23;
    localparam int RANGE_SQ_W  = 2 * RANGE_W;
    localparam int STRENGTH_W  = 16;
    localparam int RING_W      = 8;
    localparam int TAG_W       = 8;
    localparam int STAMP_W     = 32;
    localparam int TIME_W      = 33;
    localparam int OUT_RANGE_W = 24;
    localparam int MUL_W       = 32;
    localparam int INDEX_W     = 32;

    localparam logic [OUT_RANGE_W-1:0] OUT_RANGE_MAX = 24'hFFFFFF;

    // floor(n / 1000) == (n * DIV1000_MUL) >> DIV1000_SHIFT for every 32-bit n
    localparam logic [MUL_W-1:0] DIV1000_MUL   = 32'd274877907;
    localparam int               DIV1000_SHIFT = 38;
    localparam int               TDIV_W        = 2 * MUL_W - DIV1000_SHIFT;

    localparam logic [TAG_W-1:0] TAG_CLASS_MASK = 8'h30;
    localparam logic [TAG_W-1:0] TAG_CLASS_A    = 8'h00;
    localparam logic [TAG_W-1:0] TAG_CLASS_B    = 8'h10;

    localparam logic [MODE_W-1:0] MODE_TAGGED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NS     = 2'd1;

    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_NS;
    localparam logic [KEEP_W-1:0]  KEEP_RESET  = 16'd1;
    localparam logic [RANGE_W-1:0] MIN_RESET   = 23'd0;
    localparam logic [RANGE_W-1:0] MAX_RESET   = 23'h7FFFFF;

    typedef enum logic [1:0] {
        REG_MODE = 2'd0,
        REG_KEEP = 2'd1,
        REG_MIN  = 2'd2,
        REG_MAX  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MODE_W-1:0]  sensor_mode;
        logic [KEEP_W-1:0]  keep_every;
        logic [RANGE_W-1:0] min_range;
        logic [RANGE_W-1:0] max_range;
    } t_cfg;

    typedef struct packed {
        logic pre_keep;
        logic is_tagged;
        logic rel_time;
    } t_job_ctl;

endpackage

>>> design/lpgf_regs.sv
// Configuration register file on the APB port.
module lpgf_regs
    import lpgf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output logic                  o_keep_wr
);

    t_cfg     r_cfg;
    logic     r_keep_wr;
    logic     wr_en;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = CFG_DATA_W'(r_cfg.sensor_mode);
            REG_KEEP: prdata = CFG_DATA_W'(r_cfg.keep_every);
            REG_MIN:  prdata = CFG_DATA_W'(r_cfg.min_range);
            REG_MAX:  prdata = CFG_DATA_W'(r_cfg.max_range);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_mode <= MODE_RESET;
            r_cfg.keep_every  <= KEEP_RESET;
            r_cfg.min_range   <= MIN_RESET;
            r_cfg.max_range   <= MAX_RESET;
            r_keep_wr         <= 1'b0;
        end else begin
            r_keep_wr <= wr_en && (reg_idx == REG_KEEP);
            if (wr_en) begin
                unique case (reg_idx)
                    REG_MODE: r_cfg.sensor_mode <= pwdata[MODE_W-1:0];
                    REG_KEEP: r_cfg.keep_every  <= pwdata[KEEP_W-1:0];
                    REG_MIN:  r_cfg.min_range   <= pwdata[RANGE_W-1:0];
                    REG_MAX:  r_cfg.max_range   <= pwdata[RANGE_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    assign o_cfg     = r_cfg;
    assign o_keep_wr = r_keep_wr;

endmodule

>>> design/lpgf_front.sv
// Front end: accepts points, tracks scan state and classifies each point.
module lpgf_front
    import lpgf_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_keep_wr,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [TAG_W-1:0]              i_point_tag,
    input  logic [STAMP_W-1:0]            i_stamp_raw,
    input  logic                          i_point_valid,
    input  logic                          i_scan_start,
    input  logic                          i_full,
    output logic                          o_push,
    output t_job_ctl                      o_ctl,
    output logic [STAMP_W-1:0]            o_first_time
);

    localparam int BIT_W = $clog2(INDEX_W);

    logic [INDEX_W-1:0]            r_index;
    logic [KEEP_W-1:0]             r_phase;
    logic signed [COORD_WIDTH-1:0] r_prev_x;
    logic signed [COORD_WIDTH-1:0] r_prev_y;
    logic signed [COORD_WIDTH-1:0] r_prev_z;
    logic [STAMP_W-1:0]            r_first_time;
    logic                          r_first_seen;
    logic                          r_busy;
    logic [BIT_W-1:0]              r_div_bit;
    logic [KEEP_W-1:0]             r_rem;

    logic [KEEP_W-1:0]  step;
    logic               accept;
    logic               is_tagged;
    logic               counted;
    logic [INDEX_W-1:0] idx_eff;
    logic [KEEP_W-1:0]  phase_eff;
    logic               seen_eff;
    logic [KEEP_W:0]    phase_inc;
    logic [KEEP_W-1:0]  phase_nxt;
    logic               decim;
    logic               tag_ok;
    logic               differs;
    logic               load_first;
    logic [KEEP_W:0]    trial;
    logic [KEEP_W:0]    rem_nxt;

    assign step      = (i_cfg.keep_every == '0) ? KEEP_W'(1) : i_cfg.keep_every;
    assign o_ready   = !r_busy && !i_keep_wr && !i_full;
    assign accept    = i_valid && o_ready;
    assign is_tagged = (i_cfg.sensor_mode == MODE_TAGGED);
    assign counted   = is_tagged || i_point_valid;

    assign idx_eff   = i_scan_start ? '0 : r_index;
    assign phase_eff = i_scan_start ? '0 : r_phase;
    assign seen_eff  = i_scan_start ? 1'b0 : r_first_seen;
    assign phase_inc = {1'b0, phase_eff} + (KEEP_W+1)'(1);
    assign phase_nxt = ((idx_eff == '1) || (phase_inc == {1'b0, step})) ?
                       '0 : phase_inc[KEEP_W-1:0];

    assign decim   = (phase_eff == '0);
    assign tag_ok  = ((i_point_tag & TAG_CLASS_MASK) == TAG_CLASS_A) ||
                     ((i_point_tag & TAG_CLASS_MASK) == TAG_CLASS_B);
    assign differs = (i_pos_x != r_prev_x) || (i_pos_y != r_prev_y) ||
                     (i_pos_z != r_prev_z);
    assign load_first = counted && !seen_eff;

    // index remainder, one bit a cycle, after a new decimation factor
    assign trial   = {r_rem, r_index[r_div_bit]};
    assign rem_nxt = (trial >= {1'b0, step}) ? (trial - {1'b0, step}) : trial;

    always_comb begin
        o_ctl.is_tagged = is_tagged;
        o_ctl.rel_time  = (i_cfg.sensor_mode > MODE_NS);
        if (is_tagged) begin
            o_ctl.pre_keep = (idx_eff != '0) && tag_ok && decim && differs;
        end else begin
            o_ctl.pre_keep = i_point_valid && decim;
        end
    end

    assign o_push       = accept;
    assign o_first_time = load_first ? i_stamp_raw : r_first_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index      <= '0;
            r_phase      <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_z     <= '0;
            r_first_time <= '0;
            r_first_seen <= 1'b0;
            r_busy       <= 1'b0;
            r_div_bit    <= '0;
            r_rem        <= '0;
        end else begin
            if (i_keep_wr) begin
                r_busy    <= 1'b1;
                r_div_bit <= BIT_W'(INDEX_W - 1);
                r_rem     <= '0;
            end else if (r_busy) begin
                r_rem <= rem_nxt[KEEP_W-1:0];
                if (r_div_bit == '0) begin
                    r_busy  <= 1'b0;
                    r_phase <= rem_nxt[KEEP_W-1:0];
                end else begin
                    r_div_bit <= r_div_bit - BIT_W'(1);
                end
            end
            if (accept) begin
                if (counted) begin
                    r_index      <= idx_eff + INDEX_W'(1);
                    r_phase      <= phase_nxt;
                    r_prev_x     <= i_pos_x;
                    r_prev_y     <= i_pos_y;
                    r_prev_z     <= i_pos_z;
                    r_first_seen <= 1'b1;
                end else if (i_scan_start) begin
                    r_index      <= '0;
                    r_phase      <= '0;
                    r_first_seen <= 1'b0;
                end
                if (load_first) begin
                    r_first_time <= i_stamp_raw;
                end
            end
        end
    end

endmodule

>>> design/lpgf_fifo.sv
// Short job queue between the front and back ends.
`include "assert_macros.svh"

module lpgf_fifo
    import lpgf_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + ADDR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + ADDR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `PROP_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `PROP_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `PROP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))

endmodule

>>> design/lpgf_back.sv
// Back end: squares, range gate, time conversion and integer square root.
`include "assert_macros.svh"

module lpgf_back
    import lpgf_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_job_valid,
    output logic                          o_pop,
    input  t_job_ctl                      i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [STRENGTH_W-1:0]         i_strength,
    input  logic [RING_W-1:0]             i_ring,
    input  logic [STAMP_W-1:0]            i_stamp,
    input  logic [STAMP_W-1:0]            i_first_time,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic                          o_kept,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [STRENGTH_W-1:0]         o_out_strength,
    output logic [RING_W-1:0]             o_out_ring,
    output logic signed [TIME_W-1:0]      o_out_time,
    output logic [OUT_RANGE_W-1:0]        o_out_range
);

    localparam int R2_W  = 2 * COORD_WIDTH;
    localparam int CNT_W = $clog2(COORD_WIDTH + 1);

    localparam logic [CNT_W-1:0] ST_X    = CNT_W'(0);
    localparam logic [CNT_W-1:0] ST_Y    = CNT_W'(1);
    localparam logic [CNT_W-1:0] ST_Z    = CNT_W'(2);
    localparam logic [CNT_W-1:0] ST_MIN  = CNT_W'(3);
    localparam logic [CNT_W-1:0] ST_MAX  = CNT_W'(4);
    localparam logic [CNT_W-1:0] ST_TIME = CNT_W'(5);
    localparam logic [CNT_W-1:0] ST_LAST = CNT_W'(6);
    localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(COORD_WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_DONE
    } t_state;

    t_state                        r_state;
    t_job_ctl                      r_ctl;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic signed [COORD_WIDTH-1:0] r_z;
    logic [STRENGTH_W-1:0]         r_strength;
    logic [RING_W-1:0]             r_ring;
    logic [STAMP_W-1:0]            r_stamp;
    logic [STAMP_W-1:0]            r_first_time;
    logic [CNT_W-1:0]              r_cnt;
    logic [2*MUL_W-1:0]            r_prod;
    logic [R2_W-1:0]               r_r2;
    logic [RANGE_SQ_W-1:0]         r_lo2;
    logic [RANGE_SQ_W-1:0]         r_hi2;
    logic [TDIV_W-1:0]             r_tdiv;
    logic [R2_W-1:0]               r_n;
    logic [R2_W-1:0]               r_res;
    logic [R2_W-1:0]               r_bit;

    logic                          r_out_valid;
    logic                          r_out_kept;
    logic signed [COORD_WIDTH-1:0] r_out_x;
    logic signed [COORD_WIDTH-1:0] r_out_y;
    logic signed [COORD_WIDTH-1:0] r_out_z;
    logic [STRENGTH_W-1:0]         r_out_strength;
    logic [RING_W-1:0]             r_out_ring;
    logic signed [TIME_W-1:0]      r_out_time;
    logic [OUT_RANGE_W-1:0]        r_out_range;

    logic [COORD_WIDTH-1:0] mag_x;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;
    logic [MUL_W-1:0]       op_a;
    logic [MUL_W-1:0]       op_b;
    logic [2*MUL_W-1:0]     mul_prod;
    logic [R2_W-1:0]        sq_sum;
    logic                   sq_fits;
    logic [2*MUL_W-1:0]     r2_ext;
    logic [2*MUL_W-1:0]     lo2_ext;
    logic [2*MUL_W-1:0]     hi2_ext;
    logic                   range_ok;
    logic [COORD_WIDTH-1:0] root;
    logic [OUT_RANGE_W-1:0] range_val;
    logic [TIME_W-1:0]      time_val;
    logic                   out_free;

    assign mag_x = r_x[COORD_WIDTH-1] ? COORD_WIDTH'(-r_x) : COORD_WIDTH'(r_x);
    assign mag_y = r_y[COORD_WIDTH-1] ? COORD_WIDTH'(-r_y) : COORD_WIDTH'(r_y);
    assign mag_z = r_z[COORD_WIDTH-1] ? COORD_WIDTH'(-r_z) : COORD_WIDTH'(r_z);

    always_comb begin
        case (r_cnt)
            ST_X: begin
                op_a = MUL_W'(mag_x);
                op_b = MUL_W'(mag_x);
            end
            ST_Y: begin
                op_a = MUL_W'(mag_y);
                op_b = MUL_W'(mag_y);
            end
            ST_Z: begin
                op_a = MUL_W'(mag_z);
                op_b = MUL_W'(mag_z);
            end
            ST_MIN: begin
                op_a = MUL_W'(i_cfg.min_range);
                op_b = MUL_W'(i_cfg.min_range);
            end
            ST_MAX: begin
                op_a = MUL_W'(i_cfg.max_range);
                op_b = MUL_W'(i_cfg.max_range);
            end
            ST_TIME: begin
                op_a = r_stamp;
                op_b = DIV1000_MUL;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_prod = op_a * op_b;

    assign sq_sum  = r_res + r_bit;
    assign sq_fits = (r_n >= sq_sum);

    assign r2_ext  = (2*MUL_W)'(r_r2);
    assign lo2_ext = (2*MUL_W)'(r_lo2);
    assign hi2_ext = (2*MUL_W)'(r_hi2);
    assign range_ok = r_ctl.is_tagged ? ((r2_ext > lo2_ext) && (r2_ext < hi2_ext)) :
                                        ((r2_ext >= lo2_ext) && (r2_ext <= hi2_ext));

    assign root      = r_res[COORD_WIDTH-1:0];
    assign range_val = r_ctl.is_tagged ? '0 :
                       ((TIME_W'(root) > TIME_W'(OUT_RANGE_MAX)) ? OUT_RANGE_MAX :
                        OUT_RANGE_W'(root));
    assign time_val  = r_ctl.rel_time ? ({1'b0, r_stamp} - {1'b0, r_first_time}) :
                                        TIME_W'(r_tdiv);

    assign out_free = !r_out_valid || i_tready;
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_ctl        <= i_ctl;
                        r_x          <= i_pos_x;
                        r_y          <= i_pos_y;
                        r_z          <= i_pos_z;
                        r_strength   <= i_strength;
                        r_ring       <= i_ring;
                        r_stamp      <= i_stamp;
                        r_first_time <= i_first_time;
                        r_cnt        <= ST_X;
                        r_state      <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_prod;
                    case (r_cnt)
                        ST_Y:    r_r2   <= r_prod[R2_W-1:0];
                        ST_Z, ST_MIN: r_r2 <= r_r2 + r_prod[R2_W-1:0];
                        ST_MAX:  r_lo2  <= r_prod[RANGE_SQ_W-1:0];
                        ST_TIME: r_hi2  <= r_prod[RANGE_SQ_W-1:0];
                        ST_LAST: r_tdiv <= r_prod[2*MUL_W-1:DIV1000_SHIFT];
                        default: ;
                    endcase
                    if (r_cnt == ST_LAST) begin
                        r_n     <= r_r2;
                        r_res   <= '0;
                        r_bit   <= R2_W'(1) << (R2_W - 2);
                        r_cnt   <= '0;
                        r_state <= r_ctl.is_tagged ? S_DONE : S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_SQRT: begin
                    if (sq_fits) begin
                        r_n   <= r_n - sq_sum;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == SQ_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_kept     <= r_ctl.pre_keep && range_ok;
                        r_out_x        <= r_x;
                        r_out_y        <= r_y;
                        r_out_z        <= r_z;
                        r_out_strength <= r_strength;
                        r_out_ring     <= r_ctl.is_tagged ? '0 : r_ring;
                        r_out_time     <= time_val;
                        r_out_range    <= range_val;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid       = r_out_valid;
    assign o_kept         = r_out_kept;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_out_z        = r_out_z;
    assign o_out_strength = r_out_strength;
    assign o_out_ring     = r_out_ring;
    assign o_out_time     = r_out_time;
    assign o_out_range    = r_out_range;

    `PROP_ASSERT(a_sqrt_spinning, i_clk, i_rst_n, (r_state == S_SQRT) |-> !r_ctl.is_tagged)
    `PROP_ASSERT(a_load_from_done, i_clk, i_rst_n, $rose(o_tvalid) |-> $past(r_state == S_DONE))
    `PROP_ASSERT(a_pop_starts_job, i_clk, i_rst_n, o_pop |=> (r_state == S_MUL) && (r_cnt == ST_X))

endmodule

>>> design/lidar_point_gate_filter.sv
// Top level of the lidar point gate filter.
//
//  channel   | dir | handshake                   | payload
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | point fields in tdata, flags in tuser
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | result fields in tdata, kept in tuser
//  apb       | in  | psel/penable, pready high   | four registers at 0x0, 0x4, 0x8, 0xC
//
// Input side takes one point a cycle until the four-entry queue fills or a keep_every rebuild runs.
// Back end works on one point at a time and pops the next only when back in idle: six products
// on one shared 32x32 multiplier, then in modes 1 to 3 an integer square root, one root bit a cycle.
// A write to keep_every holds s_axis tready low while the index remainder is rebuilt
// one bit a cycle.
// Reset is synchronous and active low; the result register holds until taken.
module lidar_point_gate_filter
    import lpgf_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x, pos_y, pos_z, strength, beam_ring, point_tag, stamp_raw, zero fill
    input  logic [((3*COORD_WIDTH+64+7)/8)*8-1:0] i_s_axis_tdata,
    // point_valid, scan_start
    input  logic [1:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // out_x, out_y, out_z, out_strength, out_ring, out_time, out_range, zero fill
    output logic [((3*COORD_WIDTH+81+7)/8)*8-1:0] o_m_axis_tdata,
    // kept
    output logic [0:0]            o_m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_W  = ((3*COORD_WIDTH+81+7)/8)*8;
    localparam int CTL_W  = $bits(t_job_ctl);
    localparam int JOB_W  = CTL_W + 2*STAMP_W + RING_W + STRENGTH_W + 3*CW;

    localparam int X_LO   = 0;
    localparam int Y_LO   = CW;
    localparam int Z_LO   = 2*CW;
    localparam int STR_LO = 3*CW;
    localparam int RNG_LO = STR_LO + STRENGTH_W;
    localparam int TAG_LO = RNG_LO + RING_W;
    localparam int STP_LO = TAG_LO + TAG_W;

    t_cfg     cfg;
    logic     keep_wr;

    logic signed [CW-1:0]  in_x;
    logic signed [CW-1:0]  in_y;
    logic signed [CW-1:0]  in_z;
    logic [STRENGTH_W-1:0] in_strength;
    logic [RING_W-1:0]     in_ring;
    logic [TAG_W-1:0]      in_tag;
    logic [STAMP_W-1:0]    in_stamp;

    logic               push;
    t_job_ctl           front_ctl;
    logic [STAMP_W-1:0] front_first;
    logic [JOB_W-1:0]   q_wdata;
    logic [JOB_W-1:0]   q_rdata;
    logic               q_full;
    logic               q_empty;
    logic               pop;

    t_job_ctl              job_ctl;
    logic [STAMP_W-1:0]    job_first;
    logic [STAMP_W-1:0]    job_stamp;
    logic [RING_W-1:0]     job_ring;
    logic [STRENGTH_W-1:0] job_strength;
    logic signed [CW-1:0]  job_x;
    logic signed [CW-1:0]  job_y;
    logic signed [CW-1:0]  job_z;

    logic                   res_kept;
    logic signed [CW-1:0]   res_x;
    logic signed [CW-1:0]   res_y;
    logic signed [CW-1:0]   res_z;
    logic [STRENGTH_W-1:0]  res_strength;
    logic [RING_W-1:0]      res_ring;
    logic signed [TIME_W-1:0] res_time;
    logic [OUT_RANGE_W-1:0] res_range;

    assign in_x        = i_s_axis_tdata[X_LO +: CW];
    assign in_y        = i_s_axis_tdata[Y_LO +: CW];
    assign in_z        = i_s_axis_tdata[Z_LO +: CW];
    assign in_strength = i_s_axis_tdata[STR_LO +: STRENGTH_W];
    assign in_ring     = i_s_axis_tdata[RNG_LO +: RING_W];
    assign in_tag      = i_s_axis_tdata[TAG_LO +: TAG_W];
    assign in_stamp    = i_s_axis_tdata[STP_LO +: STAMP_W];

    lpgf_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_keep_wr (keep_wr)
    );

    lpgf_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_keep_wr     (keep_wr),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_pos_x       (in_x),
        .i_pos_y       (in_y),
        .i_pos_z       (in_z),
        .i_point_tag   (in_tag),
        .i_stamp_raw   (in_stamp),
        .i_point_valid (i_s_axis_tuser[0]),
        .i_scan_start  (i_s_axis_tuser[1]),
        .i_full        (q_full),
        .o_push        (push),
        .o_ctl         (front_ctl),
        .o_first_time  (front_first)
    );

    assign q_wdata = {front_ctl, front_first, in_stamp, in_ring, in_strength,
                      in_z, in_y, in_x};

    lpgf_fifo #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {job_ctl, job_first, job_stamp, job_ring, job_strength,
            job_z, job_y, job_x} = q_rdata;

    lpgf_back #(
        .COORD_WIDTH (CW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_job_valid    (!q_empty),
        .o_pop          (pop),
        .i_ctl          (job_ctl),
        .i_pos_x        (job_x),
        .i_pos_y        (job_y),
        .i_pos_z        (job_z),
        .i_strength     (job_strength),
        .i_ring         (job_ring),
        .i_stamp        (job_stamp),
        .i_first_time   (job_first),
        .o_tvalid       (o_m_axis_tvalid),
        .i_tready       (i_m_axis_tready),
        .o_kept         (res_kept),
        .o_out_x        (res_x),
        .o_out_y        (res_y),
        .o_out_z        (res_z),
        .o_out_strength (res_strength),
        .o_out_ring     (res_ring),
        .o_out_time     (res_time),
        .o_out_range    (res_range)
    );

    assign o_m_axis_tdata = OUT_W'({res_range, res_time, res_ring, res_strength,
                                    res_z, res_y, res_x});
    assign o_m_axis_tuser = res_kept;

endmodule

>>> verif/lidar_point_gate_filter_tb.sv
// Self-checking testbench for the lidar point gate filter: directed table, then random scans.
module lidar_point_gate_filter_tb;
    import lpgf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 24;
    localparam int IN_W = ((3 * COORD_W + 64 + 7) / 8) * 8;
    localparam int OUT_W = ((3 * COORD_W + 81 + 7) / 8) * 8;
    localparam logic [MODE_W-1:0] MODE_REL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 45;
    localparam int LONG_HOLD = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 114;
    localparam int DIR_ROWS = 23;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [STRENGTH_W-1:0]     strength;
        logic [RING_W-1:0]         ring;
        logic [TAG_W-1:0]          tag;
        logic [STAMP_W-1:0]        stamp;
        logic                      valid;
        logic                      start;
    } t_point;

    typedef struct {
        logic                      kept;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [STRENGTH_W-1:0]     strength;
        logic [RING_W-1:0]         ring;
        logic [TIME_W-1:0]         tstamp;
        logic [OUT_RANGE_W-1:0]    range_mm;
    } t_verdict;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic               start;
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [15:0]        strength;
        logic [7:0]         ring;
        logic [7:0]         tag;
        logic [31:0]        stamp;
        logic               typed;
        logic               kept_want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata = '0;
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_axis_tdata;
    logic [0:0]            o_m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [MODE_W-1:0]  cfg_mode = MODE_RESET;
    logic [KEEP_W-1:0]  cfg_keep = KEEP_RESET;
    logic [RANGE_W-1:0] cfg_min = MIN_RESET;
    logic [RANGE_W-1:0] cfg_max = MAX_RESET;

    logic [INDEX_W-1:0]        pt_index = '0;
    logic signed [COORD_W-1:0] last_x = '0;
    logic signed [COORD_W-1:0] last_y = '0;
    logic signed [COORD_W-1:0] last_z = '0;
    logic [STAMP_W-1:0]        first_stamp = '0;
    logic                      have_first = 1'b0;

    t_verdict pending_verdicts[$];
    int       mismatch_count = 0;
    int       result_count = 0;
    int       cycle_count = 0;
    int       rx_wait = 0;
    int       hold_asked = 0;
    int       hold_done = 0;
    logic     no_idle = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{MODE_NS, 1, 1, 24'h0, 24'h0, 24'h0, 16'h0, 8'h0, 8'h0, 32'h0, 1, 1},
        '{MODE_NS, 0, 1, 24'h7FFFFF, 24'h0, 24'h0, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1, 1},
        '{MODE_NS, 0, 1, 24'h800000, 24'h0, 24'h0, 16'h1234, 8'h5A, 8'hA5, 32'd1000, 1, 0},
        '{MODE_NS, 0, 1, 24'h800000, 24'h800000, 24'h800000, 16'h0, 8'h0, 8'h0, 32'd1, 1, 0},
        '{MODE_NS, 0, 0, 24'd10, 24'd20, 24'd30, 16'd7, 8'd3, 8'h0, 32'd2000, 1, 0},
        '{MODE_NS, 1, 0, 24'd5, 24'd6, 24'd7, 16'd8, 8'd4, 8'h0, 32'd3000, 1, 0},
        '{MODE_NS, 0, 1, 24'd3, 24'd4, 24'd12, 16'd9, 8'd5, 8'h0, 32'd999, 0, 0},
        '{MODE_NS, 0, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'd1, 8'd1, 8'h0, 32'd5, 1, 0},
        '{MODE_REL, 1, 1, 24'd100, 24'h0, 24'h0, 16'd1, 8'd2, 8'h0, 32'd1000, 0, 0},
        '{MODE_REL, 0, 1, 24'd101, 24'h0, 24'h0, 16'd2, 8'd2, 8'h0, 32'd0, 0, 0},
        '{MODE_REL, 0, 0, 24'd102, 24'h0, 24'h0, 16'd3, 8'd2, 8'h0, 32'hFFFFFFFF, 0, 0},
        '{MODE_REL, 0, 1, 24'hFFFF9C, 24'h0, 24'h0, 16'd4, 8'd2, 8'h0, 32'hFFFFFFFF, 0, 0},
        '{MODE_TAGGED, 1, 1, 24'd100, 24'h0, 24'h0, 16'd5, 8'd9, 8'h00, 32'd7000, 1, 0},
        '{MODE_TAGGED, 0, 1, 24'd100, 24'h0, 24'h0, 16'd6, 8'd9, 8'h00, 32'd8000, 1, 0},
        '{MODE_TAGGED, 0, 1, 24'd200, 24'h0, 24'h0, 16'd7, 8'd9, 8'h10, 32'd9000, 1, 1},
        '{MODE_TAGGED, 0, 1, 24'd300, 24'h0, 24'h0, 16'd8, 8'd9, 8'h20, 32'd9500, 1, 0},
        '{MODE_TAGGED, 0, 1, 24'd400, 24'h0, 24'h0, 16'd9, 8'd9, 8'h30, 32'd9600, 1, 0},
        '{MODE_TAGGED, 0, 0, 24'd500, 24'h0, 24'h0, 16'd10, 8'd9, 8'hCF, 32'd9700, 0, 0},
        '{MODE_TAGGED, 0, 1, 24'h0, 24'h0, 24'h0, 16'd11, 8'd9, 8'h00, 32'd9800, 1, 0},
        '{MODE_TAGGED, 0, 1, 24'h800000, 24'h0, 24'h0, 16'd12, 8'd9, 8'h00, 32'd9900, 1, 0},
        '{MODE_TAGGED, 0, 1, 24'h7FFFFF, 24'h0, 24'h0, 16'd13, 8'd9, 8'h00, 32'd9999, 1, 0},
        '{MODE_SPARE, 1, 1, 24'd7, 24'd8, 24'd9, 16'd14, 8'd6, 8'h0, 32'd5000, 0, 0},
        '{MODE_SPARE, 0, 0, 24'd7, 24'd8, 24'd9, 16'd15, 8'd6, 8'h0, 32'd4000, 0, 0}
    };

    logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_NS, MODE_TAGGED, MODE_REL, MODE_SPARE,
        MODE_NS, MODE_TAGGED, MODE_REL, MODE_TAGGED, MODE_NS, MODE_TAGGED, MODE_REL};
    logic [KEEP_W-1:0] phase_keep [PHASES] = '{16'd1, 16'd2, 16'd3, 16'd0, 16'hFFFF, 16'd1,
        16'd1, 16'd1, 16'd4, 16'd3, 16'd1};
    logic [RANGE_W-1:0] phase_min [PHASES] = '{23'd0, 23'd300, 23'd0, 23'd1000, 23'd0, 23'd0,
        23'd500, 23'd0, 23'h7FFFFF, 23'd100, 23'd0};
    logic [RANGE_W-1:0] phase_max [PHASES] = '{23'h7FFFFF, 23'd3000, 23'd2500, 23'h7FFFFF,
        23'h7FFFFF, 23'd6000, 23'd6000, 23'd8000, 23'h7FFFFF, 23'd4500, 23'd0};

    lidar_point_gate_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_verdict gate_point(input t_point p);
        logic [63:0]        r2;
        logic [63:0]        lo2;
        logic [63:0]        hi2;
        logic [31:0]        step;
        logic [31:0]        idx;
        logic [24:0]        root;
        logic [24:0]        trial;
        logic [TAG_W-1:0]   cls;
        longint             sx;
        longint             sy;
        longint             sz;
        logic               is_tagged;
        logic               decim;
        logic               moved;
        t_verdict           v;
        is_tagged = (cfg_mode == MODE_TAGGED);
        step = (cfg_keep == '0) ? 32'd1 : 32'(cfg_keep);
        if (p.start) begin
            pt_index = '0;
            have_first = 1'b0;
        end
        sx = p.x;
        sy = p.y;
        sz = p.z;
        r2 = 64'(sx * sx + sy * sy + sz * sz);
        lo2 = 64'(cfg_min) * 64'(cfg_min);
        hi2 = 64'(cfg_max) * 64'(cfg_max);
        v.kept = 1'b0;
        if (is_tagged || p.valid) begin
            idx = pt_index;
            decim = (idx % step) == 0;
            if (!have_first) begin
                first_stamp = p.stamp;
                have_first = 1'b1;
            end
            if (is_tagged) begin
                cls = p.tag & TAG_CLASS_MASK;
                moved = (p.x != last_x) || (p.y != last_y) || (p.z != last_z);
                v.kept = (idx != 0) && (cls == TAG_CLASS_A || cls == TAG_CLASS_B) && decim
                         && moved && r2 > lo2 && r2 < hi2;
            end else begin
                v.kept = decim && r2 >= lo2 && r2 <= hi2;
            end
            pt_index = idx + 1;
            last_x = p.x;
            last_y = p.y;
            last_z = p.z;
        end
        if (cfg_mode == MODE_TAGGED || cfg_mode == MODE_NS) begin
            v.tstamp = {1'b0, p.stamp / 32'd1000};
        end else begin
            v.tstamp = {1'b0, p.stamp} - {1'b0, first_stamp};
        end
        root = '0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (25'd1 << b);
            if (64'(trial) * 64'(trial) <= r2) root = trial;
        end
        v.range_mm = is_tagged ? '0 : (root > 25'hFFFFFF ? OUT_RANGE_MAX : root[23:0]);
        v.ring = is_tagged ? '0 : p.ring;
        v.x = p.x;
        v.y = p.y;
        v.z = p.z;
        v.strength = p.strength;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                      result_count, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict    got;
        t_verdict    want;
        int unsigned gap;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (i_m_axis_tready && o_m_axis_tvalid) begin
            got.kept = o_m_axis_tuser[0];
            got.x = o_m_axis_tdata[23:0];
            got.y = o_m_axis_tdata[47:24];
            got.z = o_m_axis_tdata[71:48];
            got.strength = o_m_axis_tdata[87:72];
            got.ring = o_m_axis_tdata[95:88];
            got.tstamp = o_m_axis_tdata[128:96];
            got.range_mm = o_m_axis_tdata[152:129];
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with no point outstanding",
                                          result_count));
            end else begin
                want = pending_verdicts.pop_front();
                check_field("kept", got.kept, want.kept);
                check_field("out_x", got.x, want.x);
                check_field("out_y", got.y, want.y);
                check_field("out_z", got.z, want.z);
                check_field("out_strength", got.strength, want.strength);
                check_field("out_ring", got.ring, want.ring);
                check_field("out_time", got.tstamp, want.tstamp);
                check_field("out_range", got.range_mm, want.range_mm);
            end
            result_count++;
            if (hold_asked != hold_done) begin
                hold_done <= hold_done + 1;
                i_m_axis_tready <= 1'b0;
                rx_wait <= LONG_HOLD - 1;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 17);
                if (gap != 0) begin
                    i_m_axis_tready <= 1'b0;
                    rx_wait <= gap - 1;
                end
            end
        end else if (!i_m_axis_tready) begin
            if (rx_wait == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    task automatic send_point(input t_point p, input logic typed, input logic kept_want);
        int unsigned gap;
        t_verdict    want;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata <= {p.stamp, p.tag, p.ring, p.strength, p.z, p.y, p.x};
        i_s_axis_tuser <= {p.start, p.valid};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        want = gate_point(p);
        if (typed) want.kept = kept_want;
        pending_verdicts.insert(pending_verdicts.size(), want);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE: cfg_mode = value[MODE_W-1:0];
            REG_KEEP: cfg_keep = value[KEEP_W-1:0];
            REG_MIN:  cfg_min = value[RANGE_W-1:0];
            REG_MAX:  cfg_max = value[RANGE_W-1:0];
            default:  ;
        endcase
    endtask

    task automatic load_settings(input logic [MODE_W-1:0] mode, input logic [KEEP_W-1:0] keep,
                                 input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
        wait_drained();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_KEEP, 32'(keep));
        write_reg(REG_MIN, 32'(lo));
        write_reg(REG_MAX, 32'(hi));
    endtask

    initial begin
        t_point             pt;
        int                 scan_left;
        int                 pick;
        logic [31:0]        stamp_base;
        logic [KEEP_W-1:0]  keep;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        pt = '{default: '0};
        scan_left = 0;
        stamp_base = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cfg_mode) begin
                load_settings(dir_rows[i].mode, cfg_keep, cfg_min, cfg_max);
            end
            pt.start = dir_rows[i].start;
            pt.valid = dir_rows[i].valid;
            pt.x = dir_rows[i].x;
            pt.y = dir_rows[i].y;
            pt.z = dir_rows[i].z;
            pt.strength = dir_rows[i].strength;
            pt.ring = dir_rows[i].ring;
            pt.tag = dir_rows[i].tag;
            pt.stamp = dir_rows[i].stamp;
            send_point(pt, dir_rows[i].typed, dir_rows[i].kept_want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            keep = phase_keep[ph];
            lo = phase_min[ph];
            hi = phase_max[ph];
            if (ph == 7) begin
                keep = KEEP_W'($urandom_range(1, 4));
                lo = RANGE_W'($urandom_range(0, 2000));
                hi = RANGE_W'($urandom_range(2000, 9000));
            end
            load_settings(phase_mode[ph], keep, lo, hi);
            no_idle <= (ph == 2 || ph == 4 || ph == 6);
            if (ph == 4) hold_asked <= hold_asked + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 7 && n == PHASE_ITEMS / 2) wait_drained();
                pt.start = (scan_left == 0);
                if (pt.start) begin
                    scan_left = $urandom_range(5, 40);
                    stamp_base = $urandom;
                end
                scan_left--;
                pt.valid = $urandom_range(0, 99) < 85;
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    pt.x = COORD_W'($urandom);
                    pt.y = COORD_W'($urandom);
                    pt.z = COORD_W'($urandom);
                end else if (pick < 15) begin
                    pt.x = COORD_W'(int'($urandom_range(0, 6)) - 3);
                    pt.y = COORD_W'(int'($urandom_range(0, 6)) - 3);
                    pt.z = COORD_W'(int'($urandom_range(0, 6)) - 3);
                end else if (pick < 90) begin
                    pt.x = COORD_W'(int'($urandom_range(0, 8000)) - 4000);
                    pt.y = COORD_W'(int'($urandom_range(0, 8000)) - 4000);
                    pt.z = COORD_W'(int'($urandom_range(0, 8000)) - 4000);
                end
                pt.strength = STRENGTH_W'($urandom);
                pt.ring = RING_W'($urandom);
                pt.tag = TAG_W'($urandom);
                pt.tag[5:4] = ($urandom_range(0, 9) < 6) ? 2'($urandom_range(0, 1))
                                                         : 2'($urandom_range(2, 3));
                stamp_base += $urandom_range(0, 200000);
                pt.stamp = ($urandom_range(0, 19) == 0) ? $urandom : stamp_base;
                send_point(pt, 1'b0, 1'b0);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
